### rtl/core/thermostat_heat_cool_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Thermostat controller assertion macros
// Shared concurrent assertion forms for the thermostat controller.
// ----------------------------------------------------------------------------
`ifndef THERMOSTAT_HEAT_COOL_CONTROLLER_UNIT_MACROS_SVH
`define THERMOSTAT_HEAT_COOL_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define THC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define THC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/thc_pkg.sv
// ----------------------------------------------------------------------------
// Thermostat controller package
// Widths, codes, shared types and arithmetic helpers.
// ----------------------------------------------------------------------------
package thc_pkg;

   // sample averaging ring
   localparam int AVG_DEPTH   = 10;
   localparam int POS_W       = $clog2(AVG_DEPTH);
   localparam int SAMPLE_W    = 9;
   localparam int SUM_W       = SAMPLE_W + $clog2(AVG_DEPTH);
   localparam int AVG_SHIFT   = SUM_W + $clog2(AVG_DEPTH);
   localparam int AVG_RECIP   = ((2 ** AVG_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
   localparam int RECIP_W     = $clog2(AVG_RECIP + 1);
   localparam int AVG_PROD_W  = SUM_W + RECIP_W;
   localparam logic [SAMPLE_W-1:0] AVG_RESET = 9'd55;

   // decimal digit split of a 9-bit value
   localparam int DIG_BASE    = 10;
   localparam int DIG_SHIFT   = 13;
   localparam int DIG_RECIP   = ((2 ** DIG_SHIFT) + DIG_BASE - 1) / DIG_BASE;
   localparam int DIG_PROD_W  = SAMPLE_W + 10;

   // port widths
   localparam int FUNC_W      = 3;
   localparam int ADC_W       = 10;
   localparam int MODE_W      = 2;
   localparam int DIGIT_W     = 6;
   localparam int SETPOINT_W  = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   // event codes
   localparam logic [FUNC_W-1:0] FUNC_POWER   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DOWN    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_UP      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DISPLAY = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_SETPOINT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT_STEP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SEC  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINKS_TO_SAVE = 3'd6;

   // mode codes on the result port
   localparam logic [MODE_W-1:0] MODE_CODE_OFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_ON  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_SET = 2'd2;

   typedef enum logic [2:0] {
      MODE_OFF = 3'b001,
      MODE_ON  = 3'b010,
      MODE_SET = 3'b100
   } mode_type;

   typedef struct packed {
      logic [7:0] start_setpoint;
      logic [4:0] deadband;
      logic [3:0] setpoint_step;
      logic [7:0] lower_limit;
      logic [7:0] upper_limit;
      logic [3:0] ticks_per_second;
      logic [3:0] blinks_to_save;
   } cfg_type;

   typedef struct packed {
      logic                sample_en;
      logic [SAMPLE_W-1:0] half;
   } avg_ctl_type;

   typedef struct packed {
      logic heat;
      logic cool;
      logic led;
   } drive_type;

   typedef struct packed {
      logic [5:0] tens;
      logic [3:0] ones;
   } digits_type;

   typedef struct packed {
      logic                  heater_drive;
      logic                  cooler_drive;
      logic                  heat_led;
      logic [MODE_W-1:0]     mode;
      logic                  digit_select;
      logic [DIGIT_W-1:0]    digit_value;
      logic                  display_blank;
      logic                  save_request;
      logic [SETPOINT_W-1:0] setpoint;
      logic [SAMPLE_W-1:0]   measured_temp;
   } rsp_type;

   // ring sum / AVG_DEPTH by reciprocal multiply, exact over the sum range
   function automatic logic [SAMPLE_W-1:0] avg_div(input logic [SUM_W-1:0] sum);
      logic [AVG_PROD_W-1:0] prod;
      prod = AVG_PROD_W'(sum) * AVG_PROD_W'(AVG_RECIP);
      return prod[AVG_SHIFT +: SAMPLE_W];
   endfunction

   function automatic digits_type dec_split(input logic [SAMPLE_W-1:0] val);
      logic [DIG_PROD_W-1:0] prod;
      logic [SAMPLE_W-1:0]   rem;
      digits_type            res;
      prod     = DIG_PROD_W'(val) * DIG_PROD_W'(DIG_RECIP);
      res.tens = prod[DIG_SHIFT +: 6];
      rem      = val - SAMPLE_W'(SAMPLE_W'(res.tens) * SAMPLE_W'(DIG_BASE));
      res.ones = rem[3:0];
      return res;
   endfunction

   // one pass of the deadband rule
   function automatic drive_type control_step(
      input drive_type           cur,
      input logic                is_off,
      input logic [7:0]          tgt,
      input logic [SAMPLE_W-1:0] avg,
      input logic [4:0]          band
   );
      drive_type          nxt;
      logic signed [10:0] diff;
      logic signed [10:0] bnd;
      logic               equal;
      nxt   = cur;
      diff  = signed'({3'b000, tgt}) - signed'({2'b00, avg});
      bnd   = signed'({6'b000000, band});
      equal = ({1'b0, tgt} == avg);
      if (is_off) begin
         nxt.heat = 1'b0;
         if (!nxt.cool) nxt.led = 1'b0;
         nxt.cool = 1'b0;
         if (!nxt.heat) nxt.led = 1'b0;
      end else if (diff >= bnd) begin
         if (!nxt.heat) begin
            nxt.heat = 1'b1;
            nxt.led  = 1'b1;
         end
         if (equal || nxt.heat) begin
            nxt.cool = 1'b0;
            if (!nxt.heat) nxt.led = 1'b0;
         end
      end else if (diff <= -bnd) begin
         if (equal || nxt.cool) begin
            nxt.heat = 1'b0;
            if (!nxt.cool) nxt.led = 1'b0;
         end
         if (!nxt.cool) begin
            nxt.cool = 1'b1;
            nxt.led  = 1'b1;
         end
      end else begin
         if (equal || nxt.cool) begin
            nxt.heat = 1'b0;
            if (!nxt.cool) nxt.led = 1'b0;
         end
         if (equal || nxt.heat) begin
            nxt.cool = 1'b0;
            if (!nxt.heat) nxt.led = 1'b0;
         end
      end
      return nxt;
   endfunction

endpackage

### rtl/core/thermostat_heat_cool_controller_unit.sv
// ----------------------------------------------------------------------------
// Thermostat heat/cool controller
// Event-driven thermostat: modes, setpoint buttons, sample averaging,
// deadband heater/cooler drive and two-digit display sequencing.
// ----------------------------------------------------------------------------
// One item per clock: an event is accepted whenever the result register is
// empty or its result is being taken, and its result appears in the result
// register on the next cycle. The rate is set by the combinational state
// update (ring sum, reciprocal-multiply average, two deadband passes);
// the averaging ring sits in flip-flops, so there is no clearing pass after
// reset. Configuration writes take effect on the next cycle.
`include "thermostat_heat_cool_controller_unit_macros.svh"

module thermostat_heat_cool_controller_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [thc_pkg::FUNC_W-1:0]      req_func,
   input  logic [thc_pkg::ADC_W-1:0]       req_adc_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_heater_drive,
   output logic                            rsp_cooler_drive,
   output logic                            rsp_heat_led,
   output logic [thc_pkg::MODE_W-1:0]      rsp_mode,
   output logic                            rsp_digit_select,
   output logic [thc_pkg::DIGIT_W-1:0]     rsp_digit_value,
   output logic                            rsp_display_blank,
   output logic                            rsp_save_request,
   output logic [thc_pkg::SETPOINT_W-1:0]  rsp_setpoint,
   output logic [thc_pkg::SAMPLE_W-1:0]    rsp_measured_temp,
   input  logic                            csr_write_en,
   input  logic [thc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [thc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import thc_pkg::*;

   cfg_type             cfg;
   logic                setpoint_load;
   avg_ctl_type         avg_ctl;
   logic [SAMPLE_W-1:0] avg_now;
   rsp_type             rsp_next;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   thc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cfg           (cfg),
      .setpoint_load (setpoint_load)
   );

   thc_avg u_avg (
      .clock   (clock),
      .reset   (reset),
      .avg_ctl (avg_ctl),
      .avg_now (avg_now)
   );

   thc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (accept),
      .func          (req_func),
      .adc_value     (req_adc_value),
      .cfg           (cfg),
      .setpoint_load (setpoint_load),
      .avg_now       (avg_now),
      .avg_ctl       (avg_ctl),
      .rsp           (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heater_drive  = rsp_ff.heater_drive;
   assign rsp_cooler_drive  = rsp_ff.cooler_drive;
   assign rsp_heat_led      = rsp_ff.heat_led;
   assign rsp_mode          = rsp_ff.mode;
   assign rsp_digit_select  = rsp_ff.digit_select;
   assign rsp_digit_value   = rsp_ff.digit_value;
   assign rsp_display_blank = rsp_ff.display_blank;
   assign rsp_save_request  = rsp_ff.save_request;
   assign rsp_setpoint      = rsp_ff.setpoint;
   assign rsp_measured_temp = rsp_ff.measured_temp;

   `THC_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid, "accepted item lost")
   `THC_ASSERT_NOW(a_drive_exclusive, clock, reset, rsp_valid, !(rsp_heater_drive && rsp_cooler_drive), "heater and cooler both on")
   `THC_ASSERT_NOW(a_off_is_dark, clock, reset, rsp_valid && (rsp_mode == MODE_CODE_OFF), !rsp_heater_drive && !rsp_cooler_drive && rsp_display_blank, "off mode not idle")
   `THC_ASSERT_NOW(a_save_returns_on, clock, reset, rsp_valid && rsp_save_request, rsp_mode == MODE_CODE_ON, "save without return to on")
   `THC_ASSERT_NOW(a_ones_digit, clock, reset, rsp_valid && rsp_digit_select, rsp_digit_value < 6'd10, "ones digit out of range")

endmodule

### rtl/core/thc_csr.sv
// ----------------------------------------------------------------------------
// Thermostat controller configuration registers
// Write-only register file; a start setpoint write also reloads the target.
// ----------------------------------------------------------------------------
module thc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [thc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [thc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output thc_pkg::cfg_type                cfg,
   output logic                            setpoint_load
);
   import thc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    setpoint_load_ff;
   logic    setpoint_load_in;

   always_comb begin
      cfg_in           = cfg_ff;
      setpoint_load_in = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_SETPOINT: begin
               cfg_in.start_setpoint = csr_wdata;
               setpoint_load_in      = 1'b1;
            end
            CSR_DEADBAND:       cfg_in.deadband         = csr_wdata[4:0];
            CSR_SETPOINT_STEP:  cfg_in.setpoint_step    = csr_wdata[3:0];
            CSR_LOWER_LIMIT:    cfg_in.lower_limit      = csr_wdata;
            CSR_UPPER_LIMIT:    cfg_in.upper_limit      = csr_wdata;
            CSR_TICKS_PER_SEC:  cfg_in.ticks_per_second = csr_wdata[3:0];
            CSR_BLINKS_TO_SAVE: cfg_in.blinks_to_save   = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_setpoint   <= 8'd60;
         cfg_ff.deadband         <= 5'd5;
         cfg_ff.setpoint_step    <= 4'd5;
         cfg_ff.lower_limit      <= 8'd40;
         cfg_ff.upper_limit      <= 8'd70;
         cfg_ff.ticks_per_second <= 4'd10;
         cfg_ff.blinks_to_save   <= 4'd10;
         setpoint_load_ff        <= 1'b0;
      end else begin
         cfg_ff           <= cfg_in;
         setpoint_load_ff <= setpoint_load_in;
      end
   end

   // target reload strobe comes in the cycle after the register write
   assign cfg           = cfg_ff;
   assign setpoint_load = setpoint_load_ff;

endmodule

### rtl/core/thc_avg.sv
// ----------------------------------------------------------------------------
// Thermostat controller sample averager
// Ring of halved samples with a running sum; average by reciprocal multiply.
// ----------------------------------------------------------------------------
module thc_avg (
   input  logic                          clock,
   input  logic                          reset,
   input  thc_pkg::avg_ctl_type          avg_ctl,
   output logic [thc_pkg::SAMPLE_W-1:0]  avg_now
);
   import thc_pkg::*;

   logic [SAMPLE_W-1:0] ring_ff [AVG_DEPTH];
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [SAMPLE_W-1:0] average_ff;
   logic [SAMPLE_W-1:0] average_in;

   assign sum_in     = sum_ff - SUM_W'(ring_ff[pos_ff]) + SUM_W'(avg_ctl.half);
   assign average_in = avg_ctl.sample_en ? avg_div(sum_in) : average_ff;
   assign pos_in     = (pos_ff == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) ring_ff[i] <= '0;
         pos_ff     <= '0;
         sum_ff     <= '0;
         average_ff <= AVG_RESET;
      end else if (avg_ctl.sample_en) begin
         ring_ff[pos_ff] <= avg_ctl.half;
         pos_ff          <= pos_in;
         sum_ff          <= sum_in;
         average_ff      <= average_in;
      end
   end

   assign avg_now = average_in;

endmodule

### rtl/core/thc_core.sv
// ----------------------------------------------------------------------------
// Thermostat controller event core: one item a cycle while step_en is high.
// Mode, setpoint, timing counters, display digits and heater/cooler drive.
// ----------------------------------------------------------------------------
module thc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [thc_pkg::FUNC_W-1:0]    func,
   input  logic [thc_pkg::ADC_W-1:0]     adc_value,
   input  thc_pkg::cfg_type              cfg,
   input  logic                          setpoint_load,
   input  logic [thc_pkg::SAMPLE_W-1:0]  avg_now,
   output thc_pkg::avg_ctl_type          avg_ctl,
   output thc_pkg::rsp_type              rsp
);
   import thc_pkg::*;

   mode_type   mode_ff,   mode_in;
   logic [7:0] target_ff, target_in;
   logic [3:0] tick_ff,   tick_in;
   logic [3:0] blink_ff,  blink_in;
   logic       blank_ff,  blank_in;
   logic       phase_ff,  phase_in;
   drive_type  drive_ff,  drive_in;
   drive_type  drive_mid;
   drive_type  drive_pass;
   drive_type  drive_done;

   logic [7:0]          target_cur;
   logic [3:0]          tick_next;
   logic [3:0]          blink_next;
   logic [8:0]          up_sum;
   logic [SAMPLE_W-1:0] shown;
   digits_type          digits;
   logic                save;
   logic                dsel;
   logic [DIGIT_W-1:0]  dval;
   logic [MODE_W-1:0]   mode_code;

   // a pending start setpoint reload comes before the item
   assign target_cur = setpoint_load ? cfg.start_setpoint : target_ff;
   assign tick_next  = tick_ff + 4'd1;
   assign blink_next = blink_ff + 4'd1;
   assign up_sum     = {1'b0, target_cur} + {5'b00000, cfg.setpoint_step};
   assign shown      = (mode_ff == MODE_SET) ? {1'b0, target_cur} : avg_now;
   assign digits     = dec_split(shown);

   assign avg_ctl.sample_en = step_en && (mode_ff != MODE_OFF) && (func == FUNC_SAMPLE);
   assign avg_ctl.half      = adc_value[ADC_W-1:1];

   always_comb begin
      mode_in   = mode_ff;
      target_in = target_cur;
      tick_in   = tick_ff;
      blink_in  = blink_ff;
      blank_in  = blank_ff;
      phase_in  = phase_ff;
      drive_mid = drive_ff;
      save      = 1'b0;
      dsel      = 1'b0;
      dval      = '0;
      if (step_en) begin
         if (func == FUNC_POWER) begin
            mode_in = (mode_ff == MODE_OFF) ? MODE_ON : MODE_OFF;
         end else if (mode_ff != MODE_OFF) begin
            unique case (func)
               FUNC_DOWN: begin
                  blink_in = '0;
                  if (mode_ff == MODE_SET && target_cur >= cfg.lower_limit) begin
                     target_in = (target_cur >= {4'b0000, cfg.setpoint_step}) ?
                                 target_cur - {4'b0000, cfg.setpoint_step} : 8'd0;
                  end else begin
                     mode_in = MODE_SET;
                  end
               end
               FUNC_UP: begin
                  blink_in = '0;
                  if (mode_ff == MODE_SET && target_cur <= cfg.upper_limit) begin
                     target_in = up_sum[8] ? 8'hFF : up_sum[7:0];
                  end else begin
                     mode_in = MODE_SET;
                  end
               end
               FUNC_DISPLAY: begin
                  if (mode_ff == MODE_ON) blank_in = 1'b0;
                  dsel     = phase_ff;
                  dval     = phase_ff ? {2'b00, digits.ones} : digits.tens;
                  phase_in = ~phase_ff;
               end
               FUNC_SAMPLE: begin
                  if (mode_ff == MODE_ON) blank_in = 1'b0;
                  tick_in = tick_next;
                  if (tick_next == cfg.ticks_per_second) begin
                     tick_in = '0;
                     if (drive_ff.heat) drive_mid.led = ~drive_ff.led;
                     if (mode_ff == MODE_SET) begin
                        blank_in = ~blank_ff;
                        blink_in = blink_next;
                        if (blink_next == cfg.blinks_to_save) begin
                           save     = 1'b1;
                           blink_in = '0;
                           mode_in  = MODE_ON;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // rule applied twice to settle
   assign drive_pass = control_step(drive_mid, mode_in == MODE_OFF, target_in, avg_now,
                                    cfg.deadband);
   assign drive_done = control_step(drive_pass, mode_in == MODE_OFF, target_in, avg_now,
                                    cfg.deadband);
   assign drive_in   = step_en ? drive_done : drive_ff;

   always_comb begin
      unique case (mode_in)
         MODE_OFF: mode_code = MODE_CODE_OFF;
         MODE_ON:  mode_code = MODE_CODE_ON;
         MODE_SET: mode_code = MODE_CODE_SET;
         default:  mode_code = MODE_CODE_OFF;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ON;
         target_ff <= 8'd60;
         tick_ff   <= '0;
         blink_ff  <= '0;
         blank_ff  <= 1'b0;
         phase_ff  <= 1'b0;
         drive_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         target_ff <= target_in;
         tick_ff   <= tick_in;
         blink_ff  <= blink_in;
         blank_ff  <= blank_in;
         phase_ff  <= phase_in;
         drive_ff  <= drive_in;
      end
   end

   assign rsp.heater_drive  = drive_done.heat;
   assign rsp.cooler_drive  = drive_done.cool;
   assign rsp.heat_led      = drive_done.led;
   assign rsp.mode          = mode_code;
   assign rsp.digit_select  = dsel;
   assign rsp.digit_value   = dval;
   assign rsp.display_blank = (mode_in == MODE_OFF) || blank_in;
   assign rsp.save_request  = save;
   assign rsp.setpoint      = target_in;
   assign rsp.measured_temp = avg_now;

endmodule
